// ===== hw/rtl/mqts_pkg.sv =====
`default_nettype none

package mqts_pkg;

	localparam int CAPACITY = 1024;
	localparam int PTR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [2:0] KIND_ENQ   = 3'd0;
	localparam logic [2:0] KIND_DEQ   = 3'd1;
	localparam logic [2:0] KIND_FRONT = 3'd2;
	localparam logic [2:0] KIND_SIZE  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;
	localparam logic [2:0] KIND_MIN   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_VALUE = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	typedef struct packed {
		logic signed [31:0] val;
		logic signed [31:0] low;
	} entry_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic move;
	} cmd_t;

	typedef struct packed {
		logic need_move;
		logic in_empty;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mqts_ctrl.sv =====
`default_nettype none

module mqts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire mqts_pkg::stat_t  stat,
	output mqts_pkg::cmd_t        cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_MOVE_RD,
		S_MOVE_WR
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.need_move)
						state_q <= S_MOVE_WR;
					else
						state_q <= S_IDLE;
				end
				// settle state so the registered read reflects the new stack top
				S_MOVE_RD: begin
					if (stat.in_empty)
						state_q <= S_EXEC;
					else
						state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					state_q <= S_MOVE_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.load = start && (state_q == S_IDLE);
		cmd.exec = (state_q == S_EXEC) && !stat.need_move;
		cmd.move = (state_q == S_MOVE_WR);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mqts_dp.sv =====
`default_nettype none

module mqts_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mqts_pkg::cmd_t     cmd,
	output mqts_pkg::stat_t         stat,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      result_value
);

	logic [2:0]                      kind_q;
	logic signed [31:0]              value_q;
	logic [mqts_pkg::CNT_W-1:0]      in_count_q;
	logic [mqts_pkg::CNT_W-1:0]      out_count_q;
	logic                            done_q;
	logic [1:0]                      status_q;
	logic signed [31:0]              result_q;
	logic signed [31:0]              run_min_q;

	mqts_pkg::entry_t in_mem  [mqts_pkg::CAPACITY];
	mqts_pkg::entry_t out_mem [mqts_pkg::CAPACITY];
	mqts_pkg::entry_t in_rd_q;
	mqts_pkg::entry_t out_rd_q;

	logic [mqts_pkg::CNT_W-1:0]      in_top;
	logic [mqts_pkg::CNT_W-1:0]      out_top;
	logic [mqts_pkg::SUM_W-1:0]      total;
	logic                            in_empty;
	logic                            out_empty;
	logic                            full;

	// exec results
	logic [mqts_pkg::CNT_W-1:0]      in_count_d;
	logic [mqts_pkg::CNT_W-1:0]      out_count_d;
	logic [1:0]                      status_d;
	logic signed [31:0]              result_d;
	logic                            in_we;
	mqts_pkg::entry_t                in_wdata;
	logic signed [31:0]              mv_low;
	mqts_pkg::entry_t                out_wdata;

	assign in_top    = in_count_q - mqts_pkg::CNT_W'(1);
	assign out_top   = out_count_q - mqts_pkg::CNT_W'(1);
	assign total     = mqts_pkg::SUM_W'(in_count_q) + mqts_pkg::SUM_W'(out_count_q);
	assign in_empty  = (in_count_q == '0);
	assign out_empty = (out_count_q == '0);
	assign full      = (total >= mqts_pkg::SUM_W'(mqts_pkg::CAPACITY));

	always_comb begin
		stat.in_empty  = in_empty;
		stat.need_move = ((kind_q == mqts_pkg::KIND_DEQ) || (kind_q == mqts_pkg::KIND_FRONT))
			&& out_empty && !in_empty;
	end

	always_comb begin
		in_count_d   = in_count_q;
		out_count_d  = out_count_q;
		status_d     = mqts_pkg::ST_ERROR;
		result_d     = '0;
		in_we        = 1'b0;
		in_wdata.val = value_q;
		in_wdata.low = value_q;
		unique case (kind_q) inside
			mqts_pkg::KIND_ENQ: begin
				if (!full) begin
					if (!in_empty && (in_rd_q.low < value_q))
						in_wdata.low = in_rd_q.low;
					in_we      = 1'b1;
					in_count_d = in_count_q + mqts_pkg::CNT_W'(1);
					status_d   = mqts_pkg::ST_OK;
				end
			end
			mqts_pkg::KIND_DEQ, mqts_pkg::KIND_FRONT: begin
				if (!out_empty) begin
					status_d = mqts_pkg::ST_VALUE;
					result_d = out_rd_q.val;
					if (kind_q == mqts_pkg::KIND_DEQ)
						out_count_d = out_top;
				end
			end
			mqts_pkg::KIND_SIZE: begin
				status_d = mqts_pkg::ST_VALUE;
				result_d = 32'(total);
			end
			mqts_pkg::KIND_CLEAR: begin
				in_count_d  = '0;
				out_count_d = '0;
				status_d    = mqts_pkg::ST_OK;
			end
			mqts_pkg::KIND_MIN: begin
				if (!in_empty || !out_empty) begin
					status_d = mqts_pkg::ST_VALUE;
					if (in_empty)
						result_d = out_rd_q.low;
					else if (out_empty)
						result_d = in_rd_q.low;
					else if (in_rd_q.low < out_rd_q.low)
						result_d = in_rd_q.low;
					else
						result_d = out_rd_q.low;
				end
			end
			default: begin
				status_d = mqts_pkg::ST_ERROR;
			end
		endcase
	end

	// transfer step: pop input top, push onto output with running minimum
	always_comb begin
		mv_low = in_rd_q.val;
		if (!out_empty && (run_min_q < in_rd_q.val))
			mv_low = run_min_q;
		out_wdata.val = in_rd_q.val;
		out_wdata.low = mv_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				in_count_q  <= in_count_d;
				out_count_q <= out_count_d;
			end else if (cmd.move) begin
				in_count_q  <= in_top;
				out_count_q <= out_count_q + mqts_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			value_q <= value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			result_q <= result_d;
		end
		if (cmd.move)
			run_min_q <= mv_low;
	end

	// stacks: tops are read every cycle into registers, data valid in the cycle after counts settle
	always_ff @(posedge clk) begin
		if (cmd.exec && in_we)
			in_mem[in_count_q[mqts_pkg::PTR_W-1:0]] <= in_wdata;
		in_rd_q <= in_mem[in_top[mqts_pkg::PTR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.move)
			out_mem[out_count_q[mqts_pkg::PTR_W-1:0]] <= out_wdata;
		out_rd_q <= out_mem[out_top[mqts_pkg::PTR_W-1:0]];
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/min_queue_two_stacks_core.sv =====
// Channel   Handshake               Payload
// request   start & !busy           kind[2:0], value[31:0] signed
// result    done (one-cycle strobe) status[1:0], result_value[31:0] signed
//
// A request is accepted, then executed from the registered stack tops.
// Dequeue or front with an empty output stack first moves all n input-stack
// entries through the stack memory read port, alternating write and read states.
// Reset clears both counts; stack memories are not cleared.
// The result strobe follows the execute cycle; the receiver cannot stall it.
`default_nettype none

module min_queue_two_stacks_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      result_value
);

	mqts_pkg::cmd_t  cmd;
	mqts_pkg::stat_t stat;

	mqts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	mqts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.value        (value),
		.done         (done),
		.status       (status),
		.result_value (result_value)
	);

endmodule

`default_nettype wire

// ===== sim/fifo_min_sb_pkg.sv =====
`timescale 1ns / 1ps

package fifo_min_sb_pkg;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] data;
	} reply_t;

	class fifo_min_scoreboard;
		// tail takes enqueues, head serves the front
		mqts_pkg::entry_t tail_stack [mqts_pkg::CAPACITY];
		mqts_pkg::entry_t head_stack [mqts_pkg::CAPACITY];
		int     tail_count;
		int     head_count;
		reply_t pending_replies [$];
		int     mismatches;
		int     n_requests;
		int     n_replies;
		int     n_full;
		int     n_empty;
		int     n_transfers;
		int     peak_fill;

		function new();
			tail_count  = 0;
			head_count  = 0;
			mismatches  = 0;
			n_requests  = 0;
			n_replies   = 0;
			n_full      = 0;
			n_empty     = 0;
			n_transfers = 0;
			peak_fill   = 0;
		endfunction

		function int occupancy();
			return tail_count + head_count;
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction

		function logic signed [31:0] lesser(logic signed [31:0] a, logic signed [31:0] b);
			return (a < b) ? a : b;
		endfunction

		function void note_request(logic [2:0] kind, logic signed [31:0] value);
			reply_t             r;
			logic signed [31:0] m;
			logic signed [31:0] e;
			r.status = mqts_pkg::ST_ERROR;
			r.data   = '0;
			n_requests++;
			case (kind) inside
			mqts_pkg::KIND_ENQ: begin
				if (occupancy() >= mqts_pkg::CAPACITY) begin
					n_full++;
				end else begin
					m = (tail_count == 0) ? value
						: lesser(value, tail_stack[tail_count - 1].low);
					tail_stack[tail_count].val = value;
					tail_stack[tail_count].low = m;
					tail_count++;
					r.status = mqts_pkg::ST_OK;
				end
			end
			mqts_pkg::KIND_DEQ, mqts_pkg::KIND_FRONT: begin
				if (occupancy() == 0) begin
					n_empty++;
				end else begin
					if (head_count == 0) begin
						n_transfers++;
						// reverse the tail onto the head, rebuilding running minima
						while (tail_count > 0 && head_count < mqts_pkg::CAPACITY) begin
							e = tail_stack[tail_count - 1].val;
							tail_count--;
							m = (head_count == 0) ? e
								: lesser(e, head_stack[head_count - 1].low);
							head_stack[head_count].val = e;
							head_stack[head_count].low = m;
							head_count++;
						end
					end
					r.status = mqts_pkg::ST_VALUE;
					r.data   = head_stack[head_count - 1].val;
					if (kind == mqts_pkg::KIND_DEQ)
						head_count--;
				end
			end
			mqts_pkg::KIND_SIZE: begin
				r.status = mqts_pkg::ST_VALUE;
				r.data   = occupancy();
			end
			mqts_pkg::KIND_CLEAR: begin
				tail_count = 0;
				head_count = 0;
				r.status   = mqts_pkg::ST_OK;
			end
			mqts_pkg::KIND_MIN: begin
				if (occupancy() == 0) begin
					n_empty++;
				end else begin
					r.status = mqts_pkg::ST_VALUE;
					if (tail_count == 0)
						r.data = head_stack[head_count - 1].low;
					else if (head_count == 0)
						r.data = tail_stack[tail_count - 1].low;
					else
						r.data = lesser(tail_stack[tail_count - 1].low,
							head_stack[head_count - 1].low);
				end
			end
			default: ;
			endcase
			if (occupancy() > peak_fill)
				peak_fill = occupancy();
			pending_replies.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch @%0t: %s", $time, what);
		endtask

		task check_result(logic [1:0] status, logic signed [31:0] data);
			reply_t want;
			n_replies++;
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: status=%0d value=%0d",
					status, data));
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (data !== want.data)
					report_mismatch($sformatf("result_value %0d, want %0d", data, want.data));
			end
		endtask

		task check_drained();
			if (pending_replies.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
		endtask
	endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] KIND_BAD6 = 3'd6;
	localparam logic [2:0] KIND_BAD7 = 3'd7;
	// worst case: full transfer of the tail stack plus the longest sender gap
	localparam int WATCHDOG_LIMIT = 5 * (2 * mqts_pkg::CAPACITY + 40);
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int FILL_AFTER     = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         kind;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] result_value;

	fifo_min_sb_pkg::fifo_min_scoreboard sb = new();
	int                 idle_cycles = 0;
	bit                 no_idle = 1'b0;

	always #5 clk = ~clk;

	min_queue_two_stacks_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.value        (value),
		.done         (done),
		.status       (status),
		.result_value (result_value)
	);

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(status, result_value);
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("[min_queue_two_stacks_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7fffffff;
		1: return 32'sh80000000;
		2: return $signed($urandom_range(0, 16)) - 8;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return mqts_pkg::KIND_ENQ;
		else if (r < 58)
			return mqts_pkg::KIND_DEQ;
		else if (r < 68)
			return mqts_pkg::KIND_FRONT;
		else if (r < 83)
			return mqts_pkg::KIND_MIN;
		else if (r < 91)
			return mqts_pkg::KIND_SIZE;
		else if (r < 94)
			return mqts_pkg::KIND_CLEAR;
		else if (r < 97)
			return KIND_BAD6;
		else
			return KIND_BAD7;
	endfunction

	// start stays high across back-to-back transactions
	task automatic send(input logic [2:0] k, input logic signed [31:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(k, v);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// empty queue, fill to the brim and overflow it, force a full-depth transfer, refill with both
	// stacks live, overflow again, then clear
	task automatic fill_to_capacity();
		send(mqts_pkg::KIND_CLEAR, pick_value());
		while (sb.occupancy() < mqts_pkg::CAPACITY)
			send(mqts_pkg::KIND_ENQ, pick_value());
		repeat (3) send(mqts_pkg::KIND_ENQ, pick_value());
		send(mqts_pkg::KIND_SIZE, pick_value());
		send(mqts_pkg::KIND_MIN, pick_value());
		send(mqts_pkg::KIND_FRONT, pick_value());
		repeat ($urandom_range(2, 5)) send(mqts_pkg::KIND_DEQ, pick_value());
		while (sb.occupancy() < mqts_pkg::CAPACITY)
			send(mqts_pkg::KIND_ENQ, pick_value());
		send(mqts_pkg::KIND_ENQ, pick_value());
		send(mqts_pkg::KIND_MIN, pick_value());
		send(mqts_pkg::KIND_SIZE, pick_value());
		send(mqts_pkg::KIND_CLEAR, pick_value());
	endtask

	initial begin
		int  base;
		int  burst_len;
		int  j;
		bit  filled;
		start  <= 1'b0;
		kind   <= mqts_pkg::KIND_ENQ;
		value  <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, bad kinds, extreme values, transfers and combined minima
		send(mqts_pkg::KIND_SIZE, 32'sh7fffffff);
		send(mqts_pkg::KIND_MIN, 0);
		send(mqts_pkg::KIND_FRONT, -1);
		send(mqts_pkg::KIND_DEQ, 0);
		send(KIND_BAD6, 0);
		send(KIND_BAD7, -1);
		send(mqts_pkg::KIND_ENQ, 32'sh7fffffff);
		send(mqts_pkg::KIND_ENQ, 32'sh80000000);
		send(mqts_pkg::KIND_ENQ, 0);
		send(mqts_pkg::KIND_ENQ, -1);
		send(mqts_pkg::KIND_MIN, 0);
		send(mqts_pkg::KIND_FRONT, 0);
		send(mqts_pkg::KIND_ENQ, -5);
		send(mqts_pkg::KIND_MIN, 0);
		send(mqts_pkg::KIND_SIZE, 0);
		repeat (3) send(mqts_pkg::KIND_DEQ, 0);
		send(mqts_pkg::KIND_MIN, 0);
		send(mqts_pkg::KIND_DEQ, 0);
		send(mqts_pkg::KIND_MIN, 0);
		send(mqts_pkg::KIND_FRONT, 0);
		send(mqts_pkg::KIND_CLEAR, 0);
		send(mqts_pkg::KIND_SIZE, 0);
		send(mqts_pkg::KIND_DEQ, 0);
		wait_drained();

		base   = sb.n_requests;
		filled = 1'b0;
		while (sb.n_requests - base < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9)) inside
			[0:3]: begin
				burst_len = $urandom_range(5, 40);
				repeat (burst_len) send(pick_kind(), pick_value());
			end
			[4:5]: begin
				burst_len = $urandom_range(5, 80);
				repeat (burst_len) send(mqts_pkg::KIND_ENQ, pick_value());
				repeat (3) send($urandom_range(0, 1) ? mqts_pkg::KIND_MIN
					: mqts_pkg::KIND_SIZE, pick_value());
			end
			[6:7]: begin
				while (sb.occupancy() > 0) begin
					j = $urandom_range(0, 5);
					send(j == 0 ? mqts_pkg::KIND_MIN
						: (j == 1 ? mqts_pkg::KIND_FRONT : mqts_pkg::KIND_DEQ),
						pick_value());
				end
				send(mqts_pkg::KIND_DEQ, pick_value());
				send(mqts_pkg::KIND_MIN, pick_value());
			end
			8: wait_drained();
			default: send(pick_kind(), pick_value());
			endcase
			if (!filled && sb.n_requests - base >= FILL_AFTER) begin
				fill_to_capacity();
				filled = 1'b1;
			end
		end

		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();
		$display("covered %0d requests, %0d results, peak fill %0d of %0d",
			sb.n_requests, sb.n_replies, sb.peak_fill, mqts_pkg::CAPACITY);
		$display("  %0d full rejects, %0d empty rejects, %0d stack transfers, %0d mismatches",
			sb.n_full, sb.n_empty, sb.n_transfers, sb.mismatches);
		if (sb.mismatches == 0)
			$display("[min_queue_two_stacks_core] OK");
		else
			$display("[min_queue_two_stacks_core] ERROR");
		$finish;
	end

endmodule
